>>> rtl/sntp_pkg.sv
package sntp_pkg;

    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int unsigned CMD_CNT_W = CMD_PTR_W + 1;

    localparam int unsigned ELAPSED_W = 22;
    localparam int unsigned RX_CNT_W  = 6;
    localparam int unsigned PROD_W    = 42;
    localparam int unsigned MS_W      = 41;

    localparam logic [7:0]            REQ_FIRST    = 8'h23;
    localparam logic [RX_CNT_W-1:0]   PKT_LEN      = 6'd48;
    localparam logic [RX_CNT_W-1:0]   PKT_LAST     = 6'd47;
    localparam logic [RX_CNT_W-1:0]   STAMP_START  = 6'd40;
    localparam logic [31:0]           UNIX_OFFSET  = 32'd2208988800;
    localparam logic [9:0]            MS_PER_S     = 10'd1000;
    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = '1;

    localparam logic [31:0]           RST_SERVER_ADDR = 32'd0;
    localparam logic [15:0]           RST_SERVER_PORT = 16'd123;
    localparam logic [ELAPSED_W-1:0]  RST_TIMEOUT     = 22'd3000000;
    localparam logic [2:0]            RST_RETRIES     = 3'd3;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_BYTE  = 2'd2
    } t_req_type;

    typedef enum logic {
        OUT_TX     = 1'b0,
        OUT_FINISH = 1'b1
    } t_out_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_SERVER_ADDR = 2'd0,
        REG_SERVER_PORT = 2'd1,
        REG_TIMEOUT     = 2'd2,
        REG_RETRIES     = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEND,
        BK_MUL
    } t_back_state;

    typedef struct packed {
        logic [31:0]          server_addr;
        logic [15:0]          server_port;
        logic [ELAPSED_W-1:0] timeout_ticks;
        logic [2:0]           max_retries;
    } t_cfg;

    // one command for the back end: a full request or a finish
    typedef struct packed {
        t_out_kind   kind;
        t_status     status;
        logic [31:0] sec_off;
        logic [31:0] frac;
    } t_cmd;

endpackage

>>> rtl/sntp_regs.sv
module sntp_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sntp_pkg::t_cfg    o_cfg
);
    import sntp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.server_addr   <= RST_SERVER_ADDR;
            r_cfg.server_port   <= RST_SERVER_PORT;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
            r_cfg.max_retries   <= RST_RETRIES;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SERVER_ADDR: r_cfg.server_addr   <= pwdata;
                REG_SERVER_PORT: r_cfg.server_port   <= pwdata[15:0];
                REG_TIMEOUT:     r_cfg.timeout_ticks <= pwdata[ELAPSED_W-1:0];
                REG_RETRIES:     r_cfg.max_retries   <= pwdata[2:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SERVER_ADDR: prdata = r_cfg.server_addr;
            REG_SERVER_PORT: prdata = {16'd0, r_cfg.server_port};
            REG_TIMEOUT:     prdata = {{(32-ELAPSED_W){1'b0}}, r_cfg.timeout_ticks};
            REG_RETRIES:     prdata = {29'd0, r_cfg.max_retries};
        endcase
    end

endmodule

>>> rtl/sntp_front.sv
module sntp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sntp_pkg::t_cfg    i_cfg,
    input  logic              i_fire,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_first,
    input  logic              i_rx_last,
    input  logic [15:0]       i_rx_port,
    input  logic [31:0]       i_rx_addr,
    output logic              o_push,
    output sntp_pkg::t_cmd    o_cmd
);
    import sntp_pkg::*;

    logic                 r_phase,        n_phase;
    logic [2:0]           r_retry,        n_retry;
    logic [ELAPSED_W-1:0] r_elapsed,      n_elapsed;
    logic [RX_CNT_W-1:0]  r_rx_count,     n_rx_count;
    logic                 r_rx_match,     n_rx_match;
    logic [7:0]           r_header_first, n_header_first;
    logic [7:0]           r_header_strat, n_header_strat;
    logic [63:0]          r_stamp,        n_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= 1'b0;
            r_retry        <= '0;
            r_elapsed      <= '0;
            r_rx_count     <= '0;
            r_rx_match     <= 1'b0;
            r_header_first <= '0;
            r_header_strat <= '0;
            r_stamp        <= '0;
        end else begin
            r_phase        <= n_phase;
            r_retry        <= n_retry;
            r_elapsed      <= n_elapsed;
            r_rx_count     <= n_rx_count;
            r_rx_match     <= n_rx_match;
            r_header_first <= n_header_first;
            r_header_strat <= n_header_strat;
            r_stamp        <= n_stamp;
        end
    end

    always_comb begin
        logic [2:0]  mode;
        logic [31:0] sec;
        logic        bad;
        n_phase        = r_phase;
        n_retry        = r_retry;
        n_elapsed      = r_elapsed;
        n_rx_count     = r_rx_count;
        n_rx_match     = r_rx_match;
        n_header_first = r_header_first;
        n_header_strat = r_header_strat;
        n_stamp        = r_stamp;
        o_push         = 1'b0;
        o_cmd          = '{kind: OUT_TX, status: ST_OK, sec_off: '0, frac: '0};

        if (i_fire) begin
            unique case (i_req_type)
                REQ_START: begin
                    n_phase    = 1'b1;
                    n_retry    = '0;
                    n_elapsed  = '0;
                    n_rx_count = '0;
                    n_rx_match = 1'b0;
                    o_push     = 1'b1;
                end
                REQ_TICK: begin
                    if (r_phase) begin
                        if (r_elapsed != ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                        if (n_elapsed >= i_cfg.timeout_ticks) begin
                            o_push = 1'b1;
                            if (r_retry >= i_cfg.max_retries) begin
                                o_cmd.kind   = OUT_FINISH;
                                o_cmd.status = ST_TIMEOUT;
                                n_phase      = 1'b0;
                                n_rx_count   = '0;
                                n_rx_match   = 1'b0;
                            end else begin
                                n_retry   = r_retry + 1'b1;
                                n_elapsed = '0;
                            end
                        end
                    end
                end
                REQ_BYTE: begin
                    if (r_phase) begin
                        if (i_rx_first) begin
                            n_rx_count = '0;
                            n_rx_match = (i_rx_port == i_cfg.server_port) &&
                                         (i_rx_addr == i_cfg.server_addr);
                        end
                        if (n_rx_match && n_rx_count < PKT_LEN) begin
                            if (n_rx_count == '0) begin
                                n_header_first = i_rx_byte;
                            end else if (n_rx_count == RX_CNT_W'(1)) begin
                                n_header_strat = i_rx_byte;
                            end else if (n_rx_count >= STAMP_START) begin
                                n_stamp = {r_stamp[55:0], i_rx_byte};
                            end
                            n_rx_count = n_rx_count + 1'b1;
                        end
                        if (i_rx_last) begin
                            if (n_rx_match && n_rx_count >= PKT_LEN) begin
                                o_push     = 1'b1;
                                o_cmd.kind = OUT_FINISH;
                                n_phase    = 1'b0;
                            end
                            n_rx_count = '0;
                            n_rx_match = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // header and timestamp checks on a complete reply
        mode = n_header_first[2:0];
        sec  = n_stamp[63:32];
        bad  = (n_header_first[7:6] == 2'b11) || (n_header_strat == 8'd0) ||
               (mode != 3'd4 && mode != 3'd5) || (sec < UNIX_OFFSET);
        if (o_push && o_cmd.kind == OUT_FINISH && o_cmd.status != ST_TIMEOUT) begin
            if (bad) begin
                o_cmd.status = ST_BAD;
            end else begin
                o_cmd.status  = ST_OK;
                o_cmd.sec_off = sec - UNIX_OFFSET;
                o_cmd.frac    = n_stamp[31:0];
            end
        end
    end

endmodule

>>> rtl/sntp_cmd_fifo.sv
module sntp_cmd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sntp_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output sntp_pkg::t_cmd    o_cmd,
    output logic              o_empty,
    output logic              o_full
);
    import sntp_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;

    function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
        return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("command popped from an empty queue");

endmodule

>>> rtl/sntp_back.sv
module sntp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sntp_pkg::t_cmd    i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_out_kind,
    output logic [7:0]        o_tx_byte,
    output logic              o_tx_last,
    output logic [1:0]        o_sync_status,
    output logic [40:0]       o_unix_ms
);
    import sntp_pkg::*;

    t_back_state          r_state, n_state;
    logic [RX_CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0]    r_prod_s, r_prod_f;
    t_status              r_fin_status;
    logic                 r_out_valid, n_out_valid;
    t_out_kind            r_out_kind, n_out_kind;
    logic [7:0]           r_tx_byte, n_tx_byte;
    logic                 r_tx_last, n_tx_last;
    t_status              r_status, n_status;
    logic [MS_W-1:0]      r_unix_ms, n_unix_ms;
    logic                 w_out_free;
    logic                 w_load_mul;

    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_tx_last     = r_tx_last;
    assign o_sync_status = r_status;
    assign o_unix_ms     = r_unix_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // products of the finish conversion, one multiply each
    always_ff @(posedge i_clk) begin
        if (w_load_mul) begin
            r_prod_s     <= PROD_W'(i_cmd.sec_off) * PROD_W'(MS_PER_S);
            r_prod_f     <= PROD_W'(i_cmd.frac) * PROD_W'(MS_PER_S);
            r_fin_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_tx_byte  <= n_tx_byte;
        r_tx_last  <= n_tx_last;
        r_status   <= n_status;
        r_unix_ms  <= n_unix_ms;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_tx_byte   = r_tx_byte;
        n_tx_last   = r_tx_last;
        n_status    = r_status;
        n_unix_ms   = r_unix_ms;
        o_pop       = 1'b0;
        w_load_mul  = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == OUT_TX) begin
                        n_state = BK_SEND;
                        n_cnt   = '0;
                    end else begin
                        n_state    = BK_MUL;
                        w_load_mul = 1'b1;
                    end
                end
            end
            BK_SEND: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = OUT_TX;
                    n_tx_byte   = (r_cnt == '0) ? REQ_FIRST : 8'd0;
                    n_tx_last   = (r_cnt == PKT_LAST);
                    n_status    = ST_OK;
                    n_unix_ms   = '0;
                    n_cnt       = r_cnt + 1'b1;
                    if (r_cnt == PKT_LAST) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_MUL: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = OUT_FINISH;
                    n_tx_byte   = 8'd0;
                    n_tx_last   = 1'b0;
                    n_status    = r_fin_status;
                    // operands are zero for a failed sync, so the sum is zero too
                    n_unix_ms   = MS_W'(r_prod_s + PROD_W'(r_prod_f[PROD_W-1:32]));
                    n_state     = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    a_finish_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == OUT_FINISH |-> r_tx_byte == 8'd0 && !r_tx_last)
        else $error("finish result carries request byte fields");

    a_ms_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |-> r_unix_ms == '0)
        else $error("time reported with a failed status");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == BK_IDLE)
        else $error("command taken while busy");

endmodule

>>> rtl/sntp_client_engine.sv
// sntp client engine
// input channel (i_in_valid / o_in_stall): one request per cycle unless stalled.
// a start request queues a 48-byte sntp request, a tick advances the reply
// timer, a reply byte is checked against the configured server and collected.
// output channel (o_out_valid / i_out_stall): request bytes to transmit
// (o_out_kind 0, 0x23 then zeros, o_tx_last on byte 48) and one finish result
// (o_out_kind 1) with status ok, bad reply or timeout and unix milliseconds.
// the first result of a request passes the command queue, the sequencer state
// and the output register before it is shown. ticks and reply bytes are taken
// every cycle unless stalled; a request send occupies the output for its 48
// bytes, then the next command is fetched; a finish passes a multiply register.
// a four-entry command queue sits between the front end and the output
// sequencer; o_in_stall rises only while that queue is full.
// when the receiver stalls, the output register holds its result and the
// sequencer waits; the front end goes on until the queue fills.
// reset (synchronous, active low) returns to idle, empties the queue and loads
// the register defaults: server 0:123, timeout 3000000 ticks, 3 retries.
module sntp_client_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_rx_first,
    input  logic        i_rx_last,
    input  logic [15:0] i_rx_port,
    input  logic [31:0] i_rx_addr,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [1:0]  o_sync_status,
    output logic [40:0] o_unix_ms
);
    import sntp_pkg::*;

    t_cfg w_cfg;
    t_cmd w_push_cmd, w_head_cmd;
    logic w_push, w_pop, w_empty, w_full, w_fire;

    assign o_in_stall = w_full;
    assign w_fire     = i_in_valid && !w_full;

    sntp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sntp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_fire     (w_fire),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_rx_first (i_rx_first),
        .i_rx_last  (i_rx_last),
        .i_rx_port  (i_rx_port),
        .i_rx_addr  (i_rx_addr),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    sntp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sntp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_head_cmd),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_tx_byte     (o_tx_byte),
        .o_tx_last     (o_tx_last),
        .o_sync_status (o_sync_status),
        .o_unix_ms     (o_unix_ms)
    );

endmodule

>>> verif/sntp_client_engine_tb.sv
module sntp_client_engine_tb;
    import sntp_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          RANDOM_ITEMS  = 65;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [1:0]  LEAP_ALARM    = 2'd3;
    localparam logic [2:0]  MODE_CLIENT   = 3'd3;
    localparam logic [2:0]  MODE_SERVER   = 3'd4;
    localparam logic [2:0]  MODE_BCAST    = 3'd5;
    localparam logic [7:0]  HDR_OK        = {2'd0, 3'd4, MODE_SERVER};
    localparam logic [31:0] SRV_ADDR      = 32'hC0A8_0101;
    localparam logic [63:0] GOOD_STAMP    = {UNIX_OFFSET + 32'd1, 32'h8000_0000};

    typedef struct {
        t_out_kind     kind;
        logic [7:0]    tx_byte;
        logic          tx_last;
        t_status       status;
        logic [MS_W-1:0] unix_ms;
    } sync_out_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_rx_first = 1'b0;
    logic        i_rx_last = 1'b0;
    logic [15:0] i_rx_port = '0;
    logic [31:0] i_rx_addr = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic [1:0]  o_sync_status;
    logic [40:0] o_unix_ms;

    // predicted engine state and register copy
    logic [31:0]          cfg_addr    = RST_SERVER_ADDR;
    logic [15:0]          cfg_port    = RST_SERVER_PORT;
    logic [ELAPSED_W-1:0] cfg_timeout = RST_TIMEOUT;
    logic [2:0]           cfg_retries = RST_RETRIES;
    logic                 engine_waiting = 1'b0;
    logic [2:0]           retry_cnt = '0;
    logic [ELAPSED_W-1:0] elapsed = '0;
    logic [RX_CNT_W-1:0]  rx_cnt = '0;
    logic                 rx_match = 1'b0;
    logic [7:0]           hdr_first = '0;
    logic [7:0]           hdr_stratum = '0;
    logic [63:0]          xmit_stamp = '0;

    sync_out_t due_outputs[$];
    int        errors = 0;
    int        cycle_count = 0;
    int        items_sent = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;

    sntp_client_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_rx_byte     (i_rx_byte),
        .i_rx_first    (i_rx_first),
        .i_rx_last     (i_rx_last),
        .i_rx_port     (i_rx_port),
        .i_rx_addr     (i_rx_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_tx_byte     (o_tx_byte),
        .o_tx_last     (o_tx_last),
        .o_sync_status (o_sync_status),
        .o_unix_ms     (o_unix_ms)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    task automatic push_request();
        sync_out_t r;
        for (int i = 0; i < 48; i++) begin
            r.kind    = OUT_TX;
            r.tx_byte = (i == 0) ? REQ_FIRST : 8'h00;
            r.tx_last = (i == 47);
            r.status  = ST_OK;
            r.unix_ms = '0;
            due_outputs.push_back(r);
        end
    endtask

    task automatic push_finish(input t_status st, input logic [MS_W-1:0] ms);
        sync_out_t r;
        r.kind    = OUT_FINISH;
        r.tx_byte = 8'h00;
        r.tx_last = 1'b0;
        r.status  = st;
        r.unix_ms = ms;
        due_outputs.push_back(r);
        engine_waiting = 1'b0;
        rx_cnt = '0;
        rx_match = 1'b0;
    endtask

    task automatic predict_engine(input logic [1:0] rt, input logic [7:0] rb,
                                  input logic rf, input logic rl,
                                  input logic [15:0] rp, input logic [31:0] ra);
        logic [2:0]  mode;
        logic [31:0] sec_off;
        logic [63:0] ms_val;
        logic        bad;
        if (rt == REQ_START) begin
            engine_waiting = 1'b1;
            retry_cnt = '0;
            elapsed = '0;
            rx_cnt = '0;
            rx_match = 1'b0;
            push_request();
        end else if (engine_waiting && rt == REQ_TICK) begin
            if (elapsed != ELAPSED_MAX)
                elapsed = elapsed + 1'b1;
            if (elapsed >= cfg_timeout) begin
                if (retry_cnt >= cfg_retries) begin
                    push_finish(ST_TIMEOUT, '0);
                end else begin
                    retry_cnt = retry_cnt + 1'b1;
                    elapsed = '0;
                    push_request();
                end
            end
        end else if (engine_waiting && rt == REQ_BYTE) begin
            if (rf) begin
                rx_cnt = '0;
                rx_match = (rp == cfg_port) && (ra == cfg_addr);
            end
            if (rx_match && rx_cnt < PKT_LEN) begin
                if (rx_cnt == 0)
                    hdr_first = rb;
                else if (rx_cnt == 1)
                    hdr_stratum = rb;
                else if (rx_cnt >= STAMP_START)
                    xmit_stamp = {xmit_stamp[55:0], rb};
                rx_cnt = rx_cnt + 1'b1;
            end
            if (rl) begin
                if (rx_match && rx_cnt >= PKT_LEN) begin
                    mode = hdr_first[2:0];
                    bad = (hdr_first[7:6] == LEAP_ALARM) || (hdr_stratum == 8'd0) ||
                          (mode != MODE_SERVER && mode != MODE_BCAST) ||
                          (xmit_stamp[63:32] < UNIX_OFFSET);
                    if (bad) begin
                        push_finish(ST_BAD, '0);
                    end else begin
                        sec_off = xmit_stamp[63:32] - UNIX_OFFSET;
                        ms_val = 64'(sec_off) * 64'd1000 +
                                 ((64'(xmit_stamp[31:0]) * 64'd1000) >> 32);
                        push_finish(ST_OK, ms_val[MS_W-1:0]);
                    end
                end else begin
                    rx_cnt = '0;
                    rx_match = 1'b0;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        sync_out_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_outputs.size() == 0) begin
                $display("%0t: output with none expected: kind %0d byte %h status %0d ms %0d",
                         $time, o_out_kind, o_tx_byte, o_sync_status, o_unix_ms);
                errors++;
            end else begin
                want = due_outputs.pop_front();
                check_field("out_kind", want.kind, o_out_kind);
                check_field("tx_byte", want.tx_byte, o_tx_byte);
                check_field("tx_last", want.tx_last, o_tx_last);
                check_field("sync_status", want.status, o_sync_status);
                check_field("unix_ms", want.unix_ms, o_unix_ms);
            end
        end
    end

    // one request on the input channel, with a random gap in front
    task automatic offer_request(input logic [1:0] rt, input logic [7:0] rb,
                                 input logic rf, input logic rl,
                                 input logic [15:0] rp, input logic [31:0] ra);
        if (engine_waiting || rt == REQ_START)
            items_sent++;
        while ($urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_rx_byte  <= rb;
        i_rx_first <= rf;
        i_rx_last  <= rl;
        i_rx_port  <= rp;
        i_rx_addr  <= ra;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_engine(rt, rb, rf, rl, rp, ra);
    endtask

    task automatic offer_random(input logic [1:0] rt);
        offer_request(rt, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), $urandom);
    endtask

    // source is only driven true on the first byte, the rest carry junk
    task automatic offer_datagram(input logic [15:0] src_port, input logic [31:0] src_addr,
                                  input logic [7:0] hdr, input logic [7:0] strat,
                                  input logic [63:0] stamp, input int len);
        logic [7:0] data_b;
        for (int i = 0; i < len; i++) begin
            if (i == 0)
                data_b = hdr;
            else if (i == 1)
                data_b = strat;
            else if (i >= 40 && i < 48)
                data_b = stamp[8*(47-i) +: 8];
            else
                data_b = $urandom;
            offer_request(REQ_BYTE, data_b, i == 0, i == len - 1,
                          (i == 0) ? src_port : 16'($urandom),
                          (i == 0) ? src_addr : $urandom);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_SERVER_ADDR: cfg_addr = val;
            REG_SERVER_PORT: cfg_port = val[15:0];
            REG_TIMEOUT:     cfg_timeout = val[ELAPSED_W-1:0];
            REG_RETRIES:     cfg_retries = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] addr, input logic [15:0] port,
                              input logic [ELAPSED_W-1:0] ticks, input logic [2:0] retries);
        wait_drained();
        apb_write(REG_SERVER_ADDR, addr);
        apb_write(REG_SERVER_PORT, 32'(port));
        apb_write(REG_TIMEOUT, 32'(ticks));
        apb_write(REG_RETRIES, 32'(retries));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT, RST_SERVER_ADDR, HDR_OK, 8'd1, GOOD_STAMP, 48);
        wait_drained();
    endtask

    task automatic test_idle_requests_ignored();
        offer_random(REQ_TICK);
        offer_request(REQ_BYTE, 8'hFF, 1'b1, 1'b1, RST_SERVER_PORT, RST_SERVER_ADDR);
        offer_random(REQ_UNUSED);
        offer_random(REQ_START);
        offer_random(REQ_UNUSED);
        offer_random(REQ_TICK);
        wait_drained();
    endtask

    task automatic test_restart_and_partial();
        offer_random(REQ_START);
        for (int i = 0; i < 10; i++)
            offer_request(REQ_BYTE, HDR_OK, i == 0, 1'b0, RST_SERVER_PORT, RST_SERVER_ADDR);
        // restart drops the partial datagram, later bytes lack a first marker
        offer_random(REQ_START);
        for (int i = 0; i < 5; i++)
            offer_request(REQ_BYTE, 8'($urandom), 1'b0, i == 4, RST_SERVER_PORT,
                          RST_SERVER_ADDR);
        offer_request(REQ_BYTE, HDR_OK, 1'b1, 1'b1, RST_SERVER_PORT, RST_SERVER_ADDR);
        offer_datagram(RST_SERVER_PORT, RST_SERVER_ADDR, HDR_OK, 8'd1, GOOD_STAMP, 47);
        offer_datagram(RST_SERVER_PORT, RST_SERVER_ADDR, {2'd1, 3'd4, MODE_BCAST}, 8'd3,
                       {$urandom_range(32'hFFFF_FFFF, UNIX_OFFSET), 32'($urandom)}, 48);
        wait_drained();
    endtask

    task automatic test_timeout_and_retries();
        set_config(32'hFFFF_FFFF, 16'hFFFF, 22'd0, 3'd0);
        offer_random(REQ_START);
        offer_random(REQ_TICK);
        set_config(32'hFFFF_FFFF, 16'hFFFF, 22'd1, 3'd7);
        offer_random(REQ_START);
        repeat (8) offer_random(REQ_TICK);
        set_config(32'hFFFF_FFFF, 16'hFFFF, 22'd3, 3'd2);
        offer_random(REQ_START);
        repeat (2) offer_random(REQ_TICK);
        offer_datagram(16'hFFFF, 32'hFFFF_FFFF, HDR_OK, 8'd1, GOOD_STAMP, 48);
        wait_drained();
    endtask

    task automatic test_reply_checks();
        set_config(SRV_ADDR, RST_SERVER_PORT, ELAPSED_MAX, 3'd7);
        offer_random(REQ_START);
        offer_random(REQ_TICK);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, {LEAP_ALARM, 3'd4, MODE_SERVER}, 8'd2,
                       GOOD_STAMP, 48);
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, HDR_OK, 8'd0, GOOD_STAMP, 48);
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, {2'd0, 3'd4, MODE_CLIENT}, 8'd1,
                       GOOD_STAMP, 48);
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, {2'd1, 3'd4, MODE_BCAST}, 8'd1,
                       {UNIX_OFFSET - 32'd1, 32'hFFFF_FFFF}, 48);
        // wrong port, then wrong address, then a reply right at the epoch
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT + 16'd1, SRV_ADDR, HDR_OK, 8'd1, GOOD_STAMP, 48);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR ^ 32'd1, HDR_OK, 8'd1, GOOD_STAMP, 48);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, {2'd2, 3'd4, MODE_BCAST}, 8'hFF,
                       {UNIX_OFFSET, 32'h0}, 48);
        // largest timestamp in an oversized datagram
        offer_random(REQ_START);
        offer_datagram(RST_SERVER_PORT, SRV_ADDR, {2'd0, 3'd3, MODE_SERVER}, 8'd1,
                       64'hFFFF_FFFF_FFFF_FFFF, 52);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        set_config(32'h0, 16'h0, 22'd0, 3'd7);
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        offer_random(REQ_START);
        repeat (8) offer_random(REQ_TICK);
        repeat (3) offer_random(REQ_START);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
        logic [7:0]  hdr;
        logic [7:0]  strat;
        logic [31:0] sec;
        logic [15:0] src_port;
        logic [31:0] src_addr;
        int          len;
        int          n;
        int          scenario;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        set_config($urandom, 16'($urandom), 22'($urandom_range(6, 0)), 3'($urandom));
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            offer_random(REQ_START);
            scenario = $urandom_range(9, 0);
            if (scenario < 6) begin
                n = $urandom_range(2, 0);
                repeat (n) offer_random(REQ_TICK);
                if ($urandom_range(2, 0) == 0)
                    offer_datagram(cfg_port, cfg_addr, 8'($urandom), 8'($urandom),
                                   {$urandom, $urandom}, $urandom_range(47, 1));
                hdr = {2'($urandom_range(2, 0)), 3'($urandom),
                       ($urandom_range(1, 0) != 0) ? MODE_SERVER : MODE_BCAST};
                if ($urandom_range(9, 0) == 0)
                    hdr = $urandom;
                strat = ($urandom_range(9, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
                sec = ($urandom_range(9, 0) == 0) ? $urandom_range(UNIX_OFFSET - 1, 0)
                                                  : $urandom_range(32'hFFFF_FFFF, UNIX_OFFSET);
                len = ($urandom_range(7, 0) == 0) ? $urandom_range(47, 1)
                                                  : $urandom_range(51, 48);
                if ($urandom_range(99, 0) < 85) begin
                    src_port = cfg_port;
                    src_addr = cfg_addr;
                end else begin
                    src_port = $urandom;
                    src_addr = $urandom;
                end
                offer_datagram(src_port, src_addr, hdr, strat, {sec, 32'($urandom)}, len);
            end else if (scenario < 8) begin
                // ride the timer through every resend to the timeout finish
                for (int k = 0; k < 80 && engine_waiting; k++)
                    offer_random(REQ_TICK);
            end else begin
                n = $urandom_range(15, 5);
                repeat (n) offer_random(2'($urandom_range(2, 0)));
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_idle_requests_ignored();
        test_restart_and_partial();
        test_timeout_and_retries();
        test_reply_checks();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(66, 0);
        test_random_traffic(0, 66);
        test_random_traffic(24, 24);
        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
